/* src/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and codes of the Go-Back-N sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    localparam int PAYLOAD_W   = 64;
    localparam int REQ_W       = 2;
    localparam int SEQ_FIELD_W = 3;
    localparam int WIN_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int TIMER_W     = 2;

    localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEND    = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_SENT         = 3'd0,
        ST_REFUSED      = 3'd1,
        ST_ACK_TAKEN    = 3'd2,
        ST_ACK_CORRUPT  = 3'd3,
        ST_RETRANSMIT   = 3'd4,
        ST_TIMEOUT_IDLE = 3'd5
    } t_status;

    typedef enum logic [TIMER_W-1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } t_timer;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_REPLAY = 1'b1
    } t_state;

    typedef struct packed {
        t_status                status;
        logic                   pkt_valid;
        logic [SEQ_FIELD_W-1:0] pkt_seq;
        logic [PAYLOAD_W-1:0]   pkt_payload;
        t_timer                 timer_action;
        logic                   last;
    } t_res;

endpackage

`default_nettype wire

/* src/gbn_req_if.sv */
// ----------------------------------------------------------------------------
// gbn_req_if
// Request channel of the sender: send, acknowledgement or timer expiry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gbn_req_if import gbn_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [REQ_W-1:0]       req_type;
    logic [PAYLOAD_W-1:0]   payload;
    logic [SEQ_FIELD_W-1:0] ack_num;
    logic                   ack_good;

    modport source (
        output valid, req_type, payload, ack_num, ack_good,
        input  ready
    );

    modport sink (
        input  valid, req_type, payload, ack_num, ack_good,
        output ready
    );

endinterface

`default_nettype wire

/* src/gbn_rsp_if.sv */
// ----------------------------------------------------------------------------
// gbn_rsp_if
// Result channel of the sender: status and packets to put on the link.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gbn_rsp_if import gbn_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic                   pkt_valid;
    logic [SEQ_FIELD_W-1:0] pkt_seq;
    logic [PAYLOAD_W-1:0]   pkt_payload;
    logic [TIMER_W-1:0]     timer_action;
    logic                   last;

    modport source (
        output valid, status, pkt_valid, pkt_seq, pkt_payload, timer_action, last,
        input  ready
    );

    modport sink (
        input  valid, status, pkt_valid, pkt_seq, pkt_payload, timer_action, last,
        output ready
    );

endinterface

`default_nettype wire

/* src/gbn_ram.sv */
// ----------------------------------------------------------------------------
// gbn_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // The read data holds until the next read enable.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/gbn_out.sv */
// ----------------------------------------------------------------------------
// gbn_out
// Output register of the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_out import gbn_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_res  i_res,
    output logic       o_free,
    gbn_rsp_if.source  o_rsp
);

    logic r_valid;
    logic n_valid;
    t_res r_res;

    assign o_free = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.status       = r_res.status;
    assign o_rsp.pkt_valid    = r_res.pkt_valid;
    assign o_rsp.pkt_seq      = r_res.pkt_seq;
    assign o_rsp.pkt_payload  = r_res.pkt_payload;
    assign o_rsp.timer_action = r_res.timer_action;
    assign o_rsp.last         = r_res.last;

endmodule

`default_nettype wire

/* src/gbn_ctrl.sv */
// ----------------------------------------------------------------------------
// gbn_ctrl
// Window state, request decoding and the retransmission sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_ctrl import gbn_pkg::*; #(
    parameter int SEQ_SPACE    = 8,
    parameter int PAYLOAD_BITS = 64,
    localparam int SEQ_W = $clog2(SEQ_SPACE)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [WIN_W-1:0]        i_cfg_wdata,
    gbn_req_if.sink                      i_req,
    input  wire logic                    i_out_free,
    output logic                         o_load,
    output t_res                         o_res,
    output logic                         o_ram_we,
    output logic [SEQ_W-1:0]             o_ram_waddr,
    output logic [PAYLOAD_BITS-1:0]      o_ram_wdata,
    output logic                         o_ram_re,
    output logic [SEQ_W-1:0]             o_ram_raddr,
    input  wire logic [PAYLOAD_BITS-1:0] i_ram_rdata
);

    localparam logic [SEQ_W:0] SEQ_LIM = (SEQ_W+1)'(SEQ_SPACE);

    // Reduces a 3-bit field modulo the sequence space.
    function automatic logic [SEQ_W-1:0] f_mod3(input logic [2:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int k = 0; k < 4; k++) begin
            if (t >= 9'(SEQ_SPACE)) begin
                t = t - 9'(SEQ_SPACE);
            end
        end
        return t[SEQ_W-1:0];
    endfunction

    function automatic logic [SEQ_W-1:0] f_add(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SEQ_LIM) begin
            s = s - SEQ_LIM;
        end
        return s[SEQ_W-1:0];
    endfunction

    function automatic logic [SEQ_W-1:0] f_sub(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + SEQ_LIM - {1'b0, b};
        if (s >= SEQ_LIM) begin
            s = s - SEQ_LIM;
        end
        return s[SEQ_W-1:0];
    endfunction

    function automatic logic [SEQ_FIELD_W-1:0] f_seq_field(input logic [SEQ_W-1:0] s);
        logic [7:0] w;
        w = 8'(s);
        return w[SEQ_FIELD_W-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [WIN_W-1:0]  r_win;
    logic [SEQ_W-1:0]  r_base, n_base;
    logic [SEQ_W-1:0]  r_next, n_next;
    logic [SEQ_W-1:0]  r_rd_seq, n_rd_seq;
    logic [SEQ_W-1:0]  r_left, n_left;
    logic              r_first, n_first;
    logic              r_pend, n_pend;
    logic [SEQ_W-1:0]  r_pend_seq, n_pend_seq;
    logic              r_pend_first, n_pend_first;
    logic              r_pend_last, n_pend_last;

    t_req              req;
    logic              in_ready;
    logic              accept;
    logic              issue;
    logic              pend_take;
    logic [SEQ_W-1:0]  count;
    logic [SEQ_W-1:0]  ack_base;
    logic              is_full;
    logic              imm_load;
    t_res              imm;
    t_res              rep;

    assign req       = t_req'(i_req.req_type);
    assign count     = f_sub(r_next, r_base);
    assign ack_base  = f_add(f_mod3(i_req.ack_num), SEQ_W'(1));
    assign is_full   = f_add(r_base, f_mod3(r_win)) == r_next;
    assign pend_take = r_pend && i_out_free;
    assign accept    = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && req == REQ_TIMEOUT && count != '0) begin
                    n_state = S_REPLAY;
                end
            end
            S_REPLAY: begin
                if (issue && r_left == SEQ_W'(1)) begin
                    n_state = S_REPLAY == r_state ? S_IDLE : r_state;
                end
            end
        endcase
    end

    // State outputs. New requests wait until the last replayed packet has
    // left the store's read register, so the store is never written while
    // a replay reads it.
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = !r_pend && i_out_free;
            end
            S_REPLAY: begin
                issue = !r_pend || pend_take;
            end
        endcase
    end

    // Datapath.
    always_comb begin
        n_base       = r_base;
        n_next       = r_next;
        n_rd_seq     = r_rd_seq;
        n_left       = r_left;
        n_first      = r_first;
        n_pend       = r_pend;
        n_pend_seq   = r_pend_seq;
        n_pend_first = r_pend_first;
        n_pend_last  = r_pend_last;
        imm_load     = 1'b0;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_next;
        o_ram_wdata  = i_req.payload[PAYLOAD_BITS-1:0];

        imm.status       = ST_SENT;
        imm.pkt_valid    = 1'b0;
        imm.pkt_seq      = '0;
        imm.pkt_payload  = '0;
        imm.timer_action = TMR_NONE;
        imm.last         = 1'b1;

        if (accept) begin
            unique case (req)
                REQ_SEND: begin
                    imm_load = 1'b1;
                    if (is_full) begin
                        imm.status = ST_REFUSED;
                    end else begin
                        imm.pkt_valid    = 1'b1;
                        imm.pkt_seq      = f_seq_field(r_next);
                        imm.pkt_payload  = PAYLOAD_W'(i_req.payload[PAYLOAD_BITS-1:0]);
                        imm.timer_action = (r_base == r_next) ? TMR_START : TMR_NONE;
                        o_ram_we         = 1'b1;
                        n_next           = f_add(r_next, SEQ_W'(1));
                    end
                end
                REQ_ACK: begin
                    imm_load = 1'b1;
                    if (i_req.ack_good) begin
                        imm.status       = ST_ACK_TAKEN;
                        imm.timer_action = (ack_base == r_next) ? TMR_STOP : TMR_RESTART;
                        n_base           = ack_base;
                    end else begin
                        imm.status = ST_ACK_CORRUPT;
                    end
                end
                REQ_TIMEOUT: begin
                    if (count == '0) begin
                        imm_load   = 1'b1;
                        imm.status = ST_TIMEOUT_IDLE;
                    end else begin
                        n_rd_seq = r_base;
                        n_left   = count;
                        n_first  = 1'b1;
                    end
                end
                REQ_NONE: begin
                end
            endcase
        end

        if (issue) begin
            n_pend       = 1'b1;
            n_pend_seq   = r_rd_seq;
            n_pend_first = r_first;
            n_pend_last  = r_left == SEQ_W'(1);
            n_rd_seq     = f_add(r_rd_seq, SEQ_W'(1));
            n_left       = r_left - SEQ_W'(1);
            n_first      = 1'b0;
        end else if (pend_take) begin
            n_pend = 1'b0;
        end
    end

    always_comb begin
        rep.status       = ST_RETRANSMIT;
        rep.pkt_valid    = 1'b1;
        rep.pkt_seq      = f_seq_field(r_pend_seq);
        rep.pkt_payload  = PAYLOAD_W'(i_ram_rdata);
        rep.timer_action = r_pend_first ? TMR_RESTART : TMR_NONE;
        rep.last         = r_pend_last;
    end

    assign o_ram_re    = issue;
    assign o_ram_raddr = r_rd_seq;
    assign o_load      = pend_take || (accept && imm_load);
    assign o_res       = pend_take ? rep : imm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_win   <= WIN_RESET;
            r_base  <= '0;
            r_next  <= '0;
            r_left  <= '0;
            r_first <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            r_base  <= n_base;
            r_next  <= n_next;
            r_left  <= n_left;
            r_first <= n_first;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_seq     <= n_rd_seq;
        r_pend_seq   <= n_pend_seq;
        r_pend_first <= n_pend_first;
        r_pend_last  <= n_pend_last;
    end

    a_replay_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REPLAY |-> r_left != '0)
        else $error("replay active with no packets left");

    a_replay_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && req == REQ_TIMEOUT && count != '0
        |=> r_state == S_REPLAY && r_left == $past(count))
        else $error("timeout with outstanding packets did not start a replay");

    a_no_write_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REPLAY || r_pend |-> !o_ram_we)
        else $error("store written while a replay reads it");

    a_pend_after_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && r_state == S_IDLE |-> r_pend_last)
        else $error("replay ended before its final packet was read");

endmodule

`default_nettype wire

/* src/go_back_n_sender.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N ARQ sender. Sends, acknowledgements, corrupt acknowledgements and
// timer expiries with nothing outstanding give one result each, so a request
// can be taken every cycle while the result side keeps up. A timer expiry
// with N packets outstanding gives N results, one per cycle while the result
// side keeps up, paced by the single read port of the packet store; the
// request side is held until the last of them is loaded into the output
// register. The packet store needs no clearing after reset, and the window
// size register may be written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender import gbn_pkg::*; #(
    parameter int SEQ_SPACE    = 8,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [WIN_W-1:0] i_cfg_wdata,
    gbn_req_if.sink               i_req,
    gbn_rsp_if.source             o_rsp
);

    localparam int SEQ_W = $clog2(SEQ_SPACE);

    logic                    out_free;
    logic                    load;
    t_res                    res;
    logic                    ram_we;
    logic [SEQ_W-1:0]        ram_waddr;
    logic [PAYLOAD_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [SEQ_W-1:0]        ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    gbn_ctrl #(
        .SEQ_SPACE    (SEQ_SPACE),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_out_free  (out_free),
        .o_load      (load),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    gbn_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SEQ_SPACE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gbn_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_free  (out_free),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
